FILE: design/disk_request_scheduler_assert.svh
// Assertion macros for the disk request scheduler
`ifndef DISK_REQUEST_SCHEDULER_ASSERT_SVH
`define DISK_REQUEST_SCHEDULER_ASSERT_SVH

// checked outside reset
`define DRS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge
`define DRS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/drs_pkg.sv
`default_nettype none
package drs_pkg;
  localparam int unsigned MAX_REQ   = 64;
  localparam int unsigned IDX_W     = $clog2(MAX_REQ);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned SEC_W     = 30;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned CYL_W     = 19;
  localparam int unsigned OFF_W     = 8;
  localparam int unsigned ROT_W     = 23;
  localparam int unsigned SEEK_W    = 25;
  localparam int unsigned SPT       = 200;
  localparam int unsigned TOP_BLOCK = 99999999;
  localparam int unsigned ROT_PERIOD = 6000000;
  localparam int unsigned SEEK_BASE = 2000000;
  localparam int unsigned SEEK_STEP = 28;
  localparam int unsigned XFER_SHIFT = 12;
  localparam int unsigned NS_PER_SECTOR = 30000;
  localparam logic [TIME_W-1:0] TIME_TOP = '1;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [SEC_W-1:0]  sector;
    logic [SIZE_W-1:0] size;
    logic [CYL_W-1:0]  cyl;
    logic [OFF_W-1:0]  off;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

FILE: design/disk_request_scheduler.sv
// Load: each item is accepted in IDLE, then LDIV waits for the shared divide by 200.
// Scheduling: per result, an entry scan through the one RAM read port, then pick,
// read, the divide of the end sector and the output state, which holds on out_stall.
// A batch of n requests is scheduled once its last item is loaded, giving n results.
// Synchronous active-high reset clears the sequencer, counters, flags; policy = 1.
`default_nettype none
module disk_request_scheduler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [47:0] arrival_ns,
  input  wire logic [26:0] block_number,
  input  wire logic [15:0] size_units,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       req_index,
  output logic [47:0]      arrival_out,
  output logic [47:0]      finish_ns,
  output logic [47:0]      wait_ns,
  output logic [29:0]      end_sector,
  output logic [18:0]      cylinder_out,
  output logic [2:0]       surface_out,
  output logic [7:0]       sector_after,
  output logic [18:0]      seek_distance,
  output logic             last_out
);
  localparam int unsigned IW = drs_pkg::IDX_W;
  localparam int unsigned CN = drs_pkg::CNT_W;
  localparam int unsigned TW = drs_pkg::TIME_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LDIV  = 4'd1;
  localparam logic [3:0] ST_START = 4'd2;
  localparam logic [3:0] ST_SCAN  = 4'd3;
  localparam logic [3:0] ST_PICK  = 4'd4;
  localparam logic [3:0] ST_CALC  = 4'd5;
  localparam logic [3:0] ST_SDIV  = 4'd6;
  localparam logic [3:0] ST_OUT   = 4'd7;

  logic [3:0] state;
  logic       policy;
  logic [CN-1:0] count;
  logic [CN-1:0] k;
  logic [drs_pkg::MAX_REQ-1:0] served;
  logic [TW-1:0] cur;
  logic [drs_pkg::CYL_W-1:0] head;
  logic [drs_pkg::ROT_W-1:0] rot;

  logic [TW-1:0] ld_arr;
  logic [drs_pkg::SEC_W-1:0] ld_sec;
  logic [drs_pkg::SIZE_W-1:0] ld_size;
  logic ld_last;

  logic [CN-1:0] scan_idx;
  logic pend_valid;
  logic [IW-1:0] pend_idx;
  logic have_first, have_best;
  logic [IW-1:0] first_idx, best_idx, sel;
  logic [TW-1:0] first_arr;
  logic [drs_pkg::CYL_W-1:0] best_d;

  logic [TW-1:0] r_arr, r_start, r_wait;
  logic [drs_pkg::CYL_W-1:0] r_cyl, r_dist;
  logic [drs_pkg::SEEK_W-1:0] r_seek, r_pos;
  logic [drs_pkg::ROT_W-1:0] r_tgt;
  logic [27:0] r_xfer;
  logic [drs_pkg::SEC_W-1:0] r_endsec;

  drs_pkg::entry_t wentry, rentry;
  logic ram_we;
  logic [IW-1:0] raddr;
  logic [drs_pkg::ENTRY_W-1:0] rdata_raw;

  logic div_start, div_done;
  logic [drs_pkg::SEC_W-1:0] div_in, div_q;
  logic [drs_pkg::OFF_W-1:0] div_r;

  logic [26:0] blk_cl;
  logic [drs_pkg::CYL_W-1:0] cyl_gap;
  logic [drs_pkg::SEEK_W-1:0] seek;
  logic [TW-1:0] start_t;
  logic [drs_pkg::SEC_W-1:0] endsec;
  logic [drs_pkg::ROT_W-1:0] pos, lat;
  logic [TW+1:0] fin_sum;
  logic [TW-1:0] fin;
  logic in_acc;

  assign in_stall = (state != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = (state == ST_OUT);
  assign rentry = drs_pkg::entry_t'(rdata_raw);

  assign blk_cl = (block_number > 27'(drs_pkg::TOP_BLOCK)) ? 27'(drs_pkg::TOP_BLOCK)
                                                           : block_number;

  assign ram_we = (state == ST_LDIV) && div_done;
  assign wentry = '{arrival: ld_arr, sector: ld_sec, size: ld_size,
                    cyl: div_q[21:3], off: div_r};

  always_comb begin
    sel = (policy && have_best) ? best_idx : first_idx;
    if (state == ST_PICK) begin
      raddr = sel;
    end else begin
      raddr = scan_idx[IW-1:0];
    end
  end

  assign cyl_gap = (rentry.cyl >= head) ? rentry.cyl - head : head - rentry.cyl;
  assign seek = (cyl_gap == '0) ? '0 : drs_pkg::SEEK_W'(drs_pkg::SEEK_BASE)
                + drs_pkg::SEEK_W'(cyl_gap) * drs_pkg::SEEK_W'(drs_pkg::SEEK_STEP);
  assign start_t = (cur > rentry.arrival) ? cur : rentry.arrival;
  assign endsec = rentry.sector + drs_pkg::SEC_W'(rentry.size);

  assign div_start = ((state == ST_IDLE) && in_acc && (count < CN'(drs_pkg::MAX_REQ)))
                     || (state == ST_CALC);
  assign div_in = (state == ST_CALC) ? endsec : {blk_cl, 3'b000};

  assign pos = r_pos[drs_pkg::ROT_W-1:0];
  assign lat = (pos <= r_tgt) ? r_tgt - pos
                              : drs_pkg::ROT_W'(drs_pkg::ROT_PERIOD) - (pos - r_tgt);
  assign fin_sum = (TW+2)'(r_start) + (TW+2)'(r_seek) + (TW+2)'(lat) + (TW+2)'(r_xfer);
  assign fin = (fin_sum > (TW+2)'(drs_pkg::TIME_TOP)) ? drs_pkg::TIME_TOP
                                                      : fin_sum[TW-1:0];

  drs_ram #(.WIDTH(drs_pkg::ENTRY_W), .DEPTH(drs_pkg::MAX_REQ)) u_ram (
    .clk(clk), .we(ram_we), .waddr(count[IW-1:0]), .wdata(wentry),
    .raddr(raddr), .rdata(rdata_raw)
  );

  drs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_in),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      policy <= 1'b1;
      count <= '0;
      k <= '0;
      served <= '0;
      cur <= '0;
      head <= '0;
      rot <= '0;
      pend_valid <= 1'b0;
      have_first <= 1'b0;
      have_best <= 1'b0;
      scan_idx <= '0;
    end else begin
      if (cfg_we) begin
        policy <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (count < CN'(drs_pkg::MAX_REQ)) begin
              state <= ST_LDIV;
            end else if (last) begin
              state <= ST_START;
            end
          end
        end
        ST_LDIV: begin
          if (div_done) begin
            served[count[IW-1:0]] <= 1'b0;
            count <= count + 1'b1;
            state <= ld_last ? ST_START : ST_IDLE;
          end
        end
        ST_START: begin
          cur <= '0;
          head <= '0;
          rot <= '0;
          k <= '0;
          scan_idx <= '0;
          pend_valid <= 1'b0;
          have_first <= 1'b0;
          have_best <= 1'b0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          pend_valid <= scan_idx < count;
          pend_idx <= scan_idx[IW-1:0];
          if (scan_idx < count) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (pend_valid && !served[pend_idx]) begin
            if (!have_first) begin
              have_first <= 1'b1;
              first_idx <= pend_idx;
              first_arr <= rentry.arrival;
            end
            if (rentry.arrival <= cur && (!have_best || cyl_gap < best_d)) begin
              have_best <= 1'b1;
              best_idx <= pend_idx;
              best_d <= cyl_gap;
            end
          end
          if (!pend_valid && scan_idx == count) begin
            state <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (policy && !have_best) begin
            cur <= first_arr;
          end
          state <= ST_CALC;
        end
        ST_CALC: begin
          state <= ST_SDIV;
        end
        ST_SDIV: begin
          if (div_done) begin
            served[sel] <= 1'b1;
            cur <= fin;
            head <= r_cyl;
            rot <= drs_pkg::ROT_W'(div_r) * drs_pkg::ROT_W'(drs_pkg::NS_PER_SECTOR);
            k <= k + 1'b1;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            scan_idx <= '0;
            pend_valid <= 1'b0;
            have_first <= 1'b0;
            have_best <= 1'b0;
            if (k == count) begin
              count <= '0;
              state <= ST_IDLE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ld_arr <= arrival_ns;
      ld_sec <= {blk_cl, 3'b000};
      ld_size <= size_units;
      ld_last <= last;
    end
    if (state == ST_CALC) begin
      r_arr <= rentry.arrival;
      r_cyl <= rentry.cyl;
      r_dist <= cyl_gap;
      r_seek <= seek;
      r_pos <= drs_pkg::SEEK_W'(rot) + seek;
      r_start <= start_t;
      r_wait <= start_t - rentry.arrival;
      r_tgt <= drs_pkg::ROT_W'(rentry.off) * drs_pkg::ROT_W'(drs_pkg::NS_PER_SECTOR);
      r_xfer <= {rentry.size, 12'b0};
      r_endsec <= endsec;
    end else if (state == ST_SDIV) begin
      // rot + seek stays below four periods
      if (r_pos >= drs_pkg::SEEK_W'(3 * drs_pkg::ROT_PERIOD)) begin
        r_pos <= r_pos - drs_pkg::SEEK_W'(3 * drs_pkg::ROT_PERIOD);
      end else if (r_pos >= drs_pkg::SEEK_W'(2 * drs_pkg::ROT_PERIOD)) begin
        r_pos <= r_pos - drs_pkg::SEEK_W'(2 * drs_pkg::ROT_PERIOD);
      end else if (r_pos >= drs_pkg::SEEK_W'(drs_pkg::ROT_PERIOD)) begin
        r_pos <= r_pos - drs_pkg::SEEK_W'(drs_pkg::ROT_PERIOD);
      end
      if (div_done) begin
        req_index <= sel;
        arrival_out <= r_arr;
        finish_ns <= fin;
        wait_ns <= r_wait;
        end_sector <= r_endsec;
        cylinder_out <= r_cyl;
        surface_out <= div_q[2:0];
        sector_after <= div_r;
        seek_distance <= r_dist;
        last_out <= (k + 1'b1) == count;
      end
    end
  end

`include "disk_request_scheduler_assert.svh"

  `DRS_ASSERT(a_batch_clears, out_valid && !out_stall && last_out |=> count == '0, "batch not cleared")
  `DRS_ASSERT(a_no_load_while_out, !in_stall |-> !out_valid, "input ready while result pending")
  `DRS_ASSERT(a_count_range, count <= CN'(drs_pkg::MAX_REQ), "load count overflow")
  `DRS_ASSERT(a_k_range, out_valid |-> k != '0 && k <= count, "served count out of range")
endmodule
`default_nettype wire

FILE: design/drs_ram.sv
`default_nettype none
module drs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/drs_div.sv
`default_nettype none
module drs_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [drs_pkg::SEC_W-1:0]  dividend,
  output logic                            done,
  output logic      [drs_pkg::SEC_W-1:0]  quotient,
  output logic      [drs_pkg::OFF_W-1:0]  remainder
);
  // x / 200 = (x >> 3) / 25 by reciprocal multiply, x % 200 = 8 * ((x >> 3) % 25) + x[2:0]
  localparam int unsigned YW = drs_pkg::SEC_W - 3;
  localparam int unsigned PW = YW + 28;
  localparam int unsigned QW = 23;
  localparam logic [27:0] RECIP = 28'd171798692;

  logic                       p1;
  logic [PW-1:0]              prod;
  logic [drs_pkg::SEC_W-1:0]  work;
  logic [QW-1:0]              q;
  logic [QW-1:0]              q_next;
  logic [4:0]                 r25;
  logic [drs_pkg::OFF_W-1:0]  rem;

  assign q_next = prod[QW+31:32];
  assign r25 = 5'(work[drs_pkg::SEC_W-1:3] - YW'(q_next) * YW'(25));
  assign quotient = drs_pkg::SEC_W'(q);
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      done <= 1'b0;
    end else begin
      p1 <= start;
      done <= p1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PW'(dividend[drs_pkg::SEC_W-1:3]) * PW'(RECIP);
      work <= dividend;
    end
    if (p1) begin
      q <= q_next;
      rem <= {r25, work[2:0]};
    end
  end
endmodule
`default_nettype wire
